// ----- sv/hsvrgb_pkg.sv -----
// shared types, sector codes and helpers for the hsv to rgb converter
package hsvrgb_pkg;

   localparam int HUE_W   = 16;
   localparam int CHAN_W  = 8;
   localparam int SECT_W  = 3;
   localparam int PROD_W  = 2 * CHAN_W;

   localparam logic [SECT_W-1:0] SEC_RED     = 3'd0;
   localparam logic [SECT_W-1:0] SEC_YELLOW  = 3'd1;
   localparam logic [SECT_W-1:0] SEC_GREEN   = 3'd2;
   localparam logic [SECT_W-1:0] SEC_CYAN    = 3'd3;
   localparam logic [SECT_W-1:0] SEC_BLUE    = 3'd4;
   localparam logic [SECT_W-1:0] SEC_MAGENTA = 3'd5;

   typedef struct packed {
      logic [CHAN_W-1:0] v;
      logic [CHAN_W-1:0] p;
      logic [CHAN_W-1:0] q;
      logic [CHAN_W-1:0] t;
   } levels_type;

   typedef struct packed {
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
   } rgb_type;

   // exact floor(x / 255) for x up to 255 * 255
   function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] x);
      logic [PROD_W:0] y;
      logic [PROD_W:0] s;
      begin
         y = {1'b0, x} + 17'd1;
         s = y + {8'd0, y[PROD_W:8]};
         div255 = s[PROD_W-1:8];
      end
   endfunction

endpackage

// ----- sv/hsvrgb_route.sv -----
// sector router: steers v, p, q and t onto the red, green and blue channels
module hsvrgb_route
   import hsvrgb_pkg::*;
(
   input  logic [SECT_W-1:0] sector,
   input  levels_type        levels,
   output rgb_type           rgb
);

   always_comb begin
      case (sector)
         SEC_RED: begin
            rgb.red = levels.v; rgb.green = levels.t; rgb.blue = levels.p;
         end
         SEC_YELLOW: begin
            rgb.red = levels.q; rgb.green = levels.v; rgb.blue = levels.p;
         end
         SEC_GREEN: begin
            rgb.red = levels.p; rgb.green = levels.v; rgb.blue = levels.t;
         end
         SEC_CYAN: begin
            rgb.red = levels.p; rgb.green = levels.q; rgb.blue = levels.v;
         end
         SEC_BLUE: begin
            rgb.red = levels.t; rgb.green = levels.p; rgb.blue = levels.v;
         end
         default: begin
            rgb.red = levels.v; rgb.green = levels.p; rgb.blue = levels.q;
         end
      endcase
   end

endmodule

// ----- sv/hsv_to_rgb_converter.sv -----
// top level of the hsv to rgb converter: four stage pipeline with stream ports
// The converter takes one hsv item per clock while req_tready is high, and returns one rgb item for each, in order.
// An accepted item passes through all four register stages before it is on the rsp side.
// Hue times six, the two saturation-fraction products, the three value products, and the
// exact divide by 255 with sector routing each get one register stage. Every stage only
// holds its item when the stage after it is full and stalled, so bubbles are squeezed
// out and a stall on rsp_tready holds all items in place without loss.
module hsv_to_rgb_converter
   import hsvrgb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // hue[15:0], saturation[23:16], brightness[31:24]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // red[7:0], green[15:8], blue[23:16]
);

   logic [HUE_W-1:0]  hue;
   logic [CHAN_W-1:0] saturation;
   logic [CHAN_W-1:0] brightness;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic go1, go2, go3, go4;

   logic [SECT_W-1:0] sec1_ff, sec2_ff, sec3_ff;
   logic [HUE_W-1:0]  frac1_ff;
   logic [CHAN_W-1:0] sat1_ff;
   logic [CHAN_W-1:0] val1_ff, val2_ff, val3_ff;
   logic [CHAN_W-1:0] ap2_ff, aq2_ff, at2_ff;
   logic [PROD_W-1:0] mp3_ff, mq3_ff, mt3_ff;
   rgb_type           rgb4_ff;

   logic [HUE_W+2:0]  scaled_in;
   logic [HUE_W:0]    comp;
   logic [23:0]       sf_prod;
   logic [23:0]       sc_prod;
   levels_type        levels;
   rgb_type           rgb_in;

   assign hue        = req_tdata[15:0];
   assign saturation = req_tdata[23:16];
   assign brightness = req_tdata[31:24];

   // stall chain
   assign go4        = !v4_ff || rsp_tready;
   assign go3        = !v3_ff || go4;
   assign go2        = !v2_ff || go3;
   assign go1        = !v1_ff || go2;
   assign req_tready = go1;

   assign scaled_in = {3'd0, hue} * 19'd6;
   assign comp      = 17'h10000 - {1'b0, frac1_ff};
   assign sf_prod   = {16'd0, sat1_ff} * {8'd0, frac1_ff};
   assign sc_prod   = {16'd0, sat1_ff} * {7'd0, comp};

   assign levels.v = val3_ff;
   assign levels.p = div255(mp3_ff);
   assign levels.q = div255(mq3_ff);
   assign levels.t = div255(mt3_ff);

   hsvrgb_route u_route (
      .sector (sec3_ff),
      .levels (levels),
      .rgb    (rgb_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (go1) v1_ff <= req_tvalid;
         if (go2) v2_ff <= v1_ff;
         if (go3) v3_ff <= v2_ff;
         if (go4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (go1) begin
         sec1_ff  <= scaled_in[HUE_W+2:HUE_W];
         frac1_ff <= scaled_in[HUE_W-1:0];
         sat1_ff  <= saturation;
         val1_ff  <= brightness;
      end
      if (go2) begin
         sec2_ff <= sec1_ff;
         val2_ff <= val1_ff;
         ap2_ff  <= 8'd255 - sat1_ff;
         aq2_ff  <= 8'd255 - sf_prod[23:16];
         at2_ff  <= 8'd255 - sc_prod[23:16];
      end
      if (go3) begin
         sec3_ff <= sec2_ff;
         val3_ff <= val2_ff;
         mp3_ff  <= {8'd0, val2_ff} * {8'd0, ap2_ff};
         mq3_ff  <= {8'd0, val2_ff} * {8'd0, aq2_ff};
         mt3_ff  <= {8'd0, val2_ff} * {8'd0, at2_ff};
      end
      if (go4) begin
         rgb4_ff <= rgb_in;
      end
   end

   assign rsp_tvalid = v4_ff;
   assign rsp_tdata  = rgb4_ff;

endmodule

// ----- tb/hsv_to_rgb_converter_tb.sv -----
// testbench for the hsv to rgb converter: directed and random colors checked against a predictor
`timescale 1ns / 100ps

module hsv_to_rgb_converter_tb
   import hsvrgb_pkg::*;
();

   localparam int CYCLE_LIMIT       = 200000;
   localparam int LONG_STALL_CYCLES = 300;
   localparam int DRAIN_CYCLES      = 20;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_RANDOM,
      READY_SPARSE,
      READY_BURSTY
   } ready_pattern_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // hue[15:0], saturation[23:16], brightness[31:24]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // red[7:0], green[15:8], blue[23:16]

   ready_pattern_type ready_pattern  = READY_ALWAYS;
   int                ready_run_left = 0;
   logic              long_stall     = 1'b0;
   event              long_stall_request;

   rgb_type expected_colors[$];
   int      failures           = 0;
   int      colors_sent        = 0;
   int      colors_checked     = 0;
   int      input_stall_cycles = 0;
   int      cycle_count        = 0;

   hsv_to_rgb_converter u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #4 clock = ~clock;

   // value scaled by k / 255, truncated
   function automatic logic [7:0] scale_level(input logic [7:0] val, input logic [7:0] k);
      logic [15:0] prod;
      prod = 16'(val) * 16'(k);
      return 8'(prod / 16'd255);
   endfunction

   function automatic rgb_type rgb_for_hsv(input logic [15:0] hue, input logic [7:0] sat,
                                           input logic [7:0] val);
      logic [18:0] hue_x6;
      logic [2:0]  sector;
      logic [15:0] frac;
      logic [23:0] sat_frac;
      logic [24:0] sat_rest;
      logic [7:0]  p, q, t;
      rgb_type     rgb;
      if (sat == 8'd0) begin
         rgb.red   = val;
         rgb.green = val;
         rgb.blue  = val;
         return rgb;
      end
      hue_x6   = 19'(hue) * 19'd6;
      sector   = hue_x6[18:16];
      frac     = hue_x6[15:0];
      sat_frac = 24'(sat) * 24'(frac);
      sat_rest = 25'(sat) * (25'h10000 - 25'(frac));
      p = scale_level(val, 8'd255 - sat);
      q = scale_level(val, 8'd255 - sat_frac[23:16]);
      t = scale_level(val, 8'd255 - sat_rest[23:16]);
      case (sector)
         SEC_RED:    begin rgb.red = val; rgb.green = t;   rgb.blue = p;   end
         SEC_YELLOW: begin rgb.red = q;   rgb.green = val; rgb.blue = p;   end
         SEC_GREEN:  begin rgb.red = p;   rgb.green = val; rgb.blue = t;   end
         SEC_CYAN:   begin rgb.red = p;   rgb.green = q;   rgb.blue = val; end
         SEC_BLUE:   begin rgb.red = t;   rgb.green = p;   rgb.blue = val; end
         default:    begin rgb.red = val; rgb.green = p;   rgb.blue = q;   end
      endcase
      return rgb;
   endfunction

   task automatic send_color(input logic [15:0] hue, input logic [7:0] sat,
                             input logic [7:0] val);
      req_tvalid <= 1'b1;
      req_tdata  <= {val, sat, hue};
      do @(posedge clock); while (!req_tready);
      expected_colors = {expected_colors, rgb_for_hsv(hue, sat, val)};
      colors_sent++;
   endtask

   task automatic idle_sender(input int cycles);
      req_tvalid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic send_random_color();
      logic [15:0] hue;
      logic [7:0]  sat;
      logic [7:0]  val;
      hue = 16'($urandom);
      if ($urandom_range(0, 4) == 0)
         hue = 16'(($urandom_range(1, 5) * 65536 + 5) / 6 + $urandom_range(0, 2) - 1);
      case ($urandom_range(0, 9))
         0:       sat = 8'd0;
         1:       sat = 8'd255;
         2:       sat = 8'd1;
         default: sat = 8'($urandom);
      endcase
      case ($urandom_range(0, 9))
         0:       val = 8'd0;
         1:       val = 8'd255;
         default: val = 8'($urandom);
      endcase
      send_color(hue, sat, val);
   endtask

   task automatic test_corner_colors();
      ready_pattern <= READY_ALWAYS;
      send_color(16'd0,     8'd0,   8'd0);
      send_color(16'hFFFF,  8'd0,   8'd255);
      send_color(16'h1234,  8'd0,   8'h5A);
      send_color(16'd0,     8'd255, 8'd255);
      send_color(16'hFFFF,  8'd255, 8'd255);
      send_color(16'd10922, 8'd255, 8'd255);
      send_color(16'd10923, 8'd255, 8'd255);
      send_color(16'd21845, 8'd255, 8'd255);
      send_color(16'd21846, 8'd255, 8'd255);
      send_color(16'd32768, 8'd255, 8'd255);
      send_color(16'd43690, 8'd255, 8'd255);
      send_color(16'd43691, 8'd255, 8'd255);
      send_color(16'd54613, 8'd255, 8'd255);
      send_color(16'd54614, 8'd255, 8'd255);
      send_color(16'd5461,  8'd1,   8'd255);
      send_color(16'd40000, 8'd128, 8'd0);
      send_color(16'hAAAA,  8'h55,  8'hAA);
      send_color(16'h5555,  8'hAA,  8'h55);
      send_color(16'd60000, 8'd200, 8'd100);
      send_color(16'd27000, 8'd255, 8'd1);
      send_color(16'h8000,  8'd254, 8'd254);
   endtask

   task automatic test_random_colors(input int count);
      int sent;
      int burst;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 7) == 0)
            ready_pattern <= ready_pattern_type'($urandom_range(0, 3));
         burst = $urandom_range(1, 24);
         repeat (burst) begin
            send_random_color();
            sent++;
         end
         if ($urandom_range(0, 3) != 0)
            idle_sender($urandom_range(1, 6));
      end
   endtask

   task automatic test_full_rate(input int count);
      ready_pattern <= READY_ALWAYS;
      repeat (count) send_random_color();
   endtask

   task automatic test_backpressure_fill(input int count);
      ready_pattern <= READY_ALWAYS;
      -> long_stall_request;
      repeat (count) send_random_color();
   endtask

   always @(posedge clock) begin
      if (reset || long_stall) begin
         rsp_tready <= 1'b0;
      end else begin
         case (ready_pattern)
            READY_ALWAYS: rsp_tready <= 1'b1;
            READY_RANDOM: rsp_tready <= ($urandom_range(0, 3) != 0);
            READY_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
            default: begin
               if (ready_run_left == 0) begin
                  ready_run_left <= $urandom_range(1, 12);
                  rsp_tready     <= ~rsp_tready;
               end else begin
                  ready_run_left <= ready_run_left - 1;
               end
            end
         endcase
      end
   end

   initial begin
      forever begin
         @(long_stall_request);
         @(posedge clock);
         long_stall <= 1'b1;
         repeat (LONG_STALL_CYCLES) @(posedge clock);
         long_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      rgb_type expected;
      rgb_type actual;
      if (req_tvalid && !req_tready)
         input_stall_cycles++;
      if (!reset && rsp_tvalid && rsp_tready) begin
         actual = rgb_type'(rsp_tdata);
         if (expected_colors.size() == 0) begin
            $error("unexpected result item: rsp_tdata %h", rsp_tdata);
            failures++;
         end else begin
            expected = expected_colors.pop_front();
            colors_checked++;
            if (actual.red !== expected.red) begin
               $error("red: expected %0d, actual %0d", expected.red, actual.red);
               failures++;
            end
            if (actual.green !== expected.green) begin
               $error("green: expected %0d, actual %0d", expected.green, actual.green);
               failures++;
            end
            if (actual.blue !== expected.blue) begin
               $error("blue: expected %0d, actual %0d", expected.blue, actual.blue);
               failures++;
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_colors.size());
      $display("** hsv_to_rgb_converter: FAILED **");
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_corner_colors();
      test_full_rate(200);
      test_random_colors(1500);
      test_backpressure_fill(40);
      idle_sender(1);
      ready_pattern <= READY_ALWAYS;
      while (expected_colors.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("sent %0d colors and checked %0d results: gray, sector edges, random mixes",
               colors_sent, colors_checked);
      $display("input held off for %0d cycles under output stalls, incl. one long hold-off",
               input_stall_cycles);
      if (failures == 0) begin
         $display("** hsv_to_rgb_converter: PASSED **");
      end else begin
         $display("** hsv_to_rgb_converter: FAILED **");
      end
      $finish;
   end

endmodule
